// ----- hw/rtl/sled_pkg.sv -----
package sled_pkg;

    // Mode codes, shared by the request and response channels
    localparam int MODE_W = 3;

    typedef enum logic [MODE_W-1:0] {
        MODE_OFF         = 3'd0,
        MODE_STARTUP     = 3'd1,
        MODE_UNSUPPORTED = 3'd2,
        MODE_BOTDETECT   = 3'd3,
        MODE_READWRITE   = 3'd4,
        MODE_ERROR       = 3'd5
    } mode_t;

    // Request kinds
    localparam logic REQ_TICK     = 1'b0;
    localparam logic REQ_SET_MODE = 1'b1;

    // Configuration register file
    localparam int CFG_COUNT = 8;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_UNSUPPORTED_BLINK = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BOTDETECT_ON      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BOTDETECT_OFF     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_READWRITE_ON      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_READWRITE_OFF     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ERROR_BLINK       = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_STARTUP_DELAY     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_READWRITE_FLASH   = 3'd7;

    typedef int unsigned cfg_reset_t [CFG_COUNT];

    localparam cfg_reset_t CFG_RESET = '{500, 100, 900, 20, 20, 100, 200, 0};

    // Phase counter and burst bookkeeping
    localparam int CNT_W   = 32;
    localparam int BURST_W = 2;

    localparam logic [BURST_W-1:0] BURST_SINGLE = 2'd1;
    localparam logic [BURST_W-1:0] BURST_DOUBLE = 2'd2;

endpackage

// ----- hw/rtl/sled_req_if.sv -----
interface sled_req_if #(
    parameter int TIME_WIDTH = 32
);
    import sled_pkg::*;

    logic                  valid;
    logic                  ready;
    logic                  req_type;
    logic [MODE_W-1:0]     new_mode;
    logic [TIME_WIDTH-1:0] now_ms;

    modport source (
        output valid,
        output req_type,
        output new_mode,
        output now_ms,
        input  ready
    );

    modport sink (
        input  valid,
        input  req_type,
        input  new_mode,
        input  now_ms,
        output ready
    );

endinterface

// ----- hw/rtl/sled_rsp_if.sv -----
interface sled_rsp_if;
    import sled_pkg::*;

    logic              valid;
    logic              ready;
    logic              led_on;
    logic [MODE_W-1:0] mode;

    modport source (
        output valid,
        output led_on,
        output mode,
        input  ready
    );

    modport sink (
        input  valid,
        input  led_on,
        input  mode,
        output ready
    );

endinterface

// ----- hw/rtl/sled_cfg_if.sv -----
interface sled_cfg_if #(
    parameter int DURATION_WIDTH = 16
);
    import sled_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [CFG_IDX_W-1:0]      index;
    logic [DURATION_WIDTH-1:0] data;

    modport source (
        output valid,
        output index,
        output data,
        input  ready
    );

    modport sink (
        input  valid,
        input  index,
        input  data,
        output ready
    );

endinterface

// ----- hw/rtl/status_led_blink_pattern_top.sv -----
// Fault LED blink-pattern generator.
//
// req  : one beat per item, either a 1 ms tick or a set-mode request, both
//        carrying the current system time now_ms.
// rsp  : one beat per accepted req beat, in order: LED level and mode after it.
// cfg  : register writes (index 0..7, duration in ms), always ready. Write
//        only while no item is in flight.
//
// Path: a req beat is taken into the input register, then into the state
// registers that drive rsp once rsp is free. Throughput is one item per cycle
// while rsp is not held: the item sits in an input register, and the
// mode/counter update is a single pass of compares and a 32-bit increment
// into the state registers, which also hold the rsp payload.
//
// Reset: mode is startup with the LED lit, configuration registers take
// their default durations. No clearing pass is needed.
// Stall: while rsp is held, the state freezes; one more req beat is taken
// into the input register, then req.ready drops until rsp moves.
module status_led_blink_pattern_top #(
    parameter int TIME_WIDTH     = 32,
    parameter int DURATION_WIDTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    sled_req_if.sink    req,
    sled_rsp_if.source  rsp,
    sled_cfg_if.sink    cfg
);
    import sled_pkg::*;

    localparam int TW = TIME_WIDTH;
    localparam int DW = DURATION_WIDTH;
    localparam int SW = (TW > DW) ? TW : DW;

    // Input register
    logic              s1_valid_reg;
    logic              s1_type_reg;
    logic [MODE_W-1:0] s1_mode_reg;
    logic [TW-1:0]     s1_now_reg;

    // Output valid
    logic              rsp_valid_reg;

    // Configuration registers
    logic [DW-1:0]     cfg_reg [CFG_COUNT];

    // Blink state
    mode_t             mode_reg,     mode_next;
    logic [CNT_W-1:0]  cnt_reg,      cnt_next;
    logic [BURST_W-1:0] blinks_reg,  blinks_next;
    logic              lit_reg,      lit_next;
    logic              led_reg,      led_next;
    logic [DW-1:0]     on_ms_reg,    on_ms_next;
    logic [DW-1:0]     off_ms_reg,   off_ms_next;
    logic [BURST_W-1:0] burst_reg,   burst_next;
    logic [TW-1:0]     flash_end_reg, flash_end_next;

    logic              advance;
    logic              rw_enabled;
    logic              startup_done;
    logic [TW-1:0]     flash_diff;
    logic              flash_expired;
    logic              use_on_limit;
    logic [DW-1:0]     phase_limit;
    logic              phase_hit;

    // Handshake: output register frees when empty or taken
    assign advance   = !rsp_valid_reg || rsp.ready;
    assign req.ready = !s1_valid_reg || advance;
    assign cfg.ready = 1'b1;

    assign rsp.valid  = rsp_valid_reg;
    assign rsp.led_on = led_reg;
    assign rsp.mode   = mode_reg;

    // Capture the incoming beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (req.ready)
            begin
                s1_valid_reg <= req.valid;
            end
            if (advance)
            begin
                rsp_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            s1_type_reg <= req.req_type;
            s1_mode_reg <= req.new_mode;
            s1_now_reg  <= req.now_ms;
        end
    end

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CFG_COUNT; i++)
            begin
                cfg_reg[i] <= DW'(CFG_RESET[i]);
            end
        end
        else if (cfg.valid && cfg.ready)
        begin
            cfg_reg[cfg.index] <= cfg.data;
        end
    end

    // Time compares
    assign rw_enabled    = (cfg_reg[CFG_READWRITE_FLASH] != '0);
    assign startup_done  = (SW'(s1_now_reg) >= SW'(cfg_reg[CFG_STARTUP_DELAY]));
    assign flash_diff    = s1_now_reg - flash_end_reg;
    assign flash_expired = rw_enabled && (mode_reg == MODE_READWRITE)
                           && (flash_diff != '0) && !flash_diff[TW-1];

    // Pick the phase limit: on-time while lit and for the in-burst gap
    assign use_on_limit = lit_reg || (blinks_reg < burst_reg);
    assign phase_limit  = use_on_limit ? on_ms_reg : off_ms_reg;
    assign phase_hit    = (cnt_reg >= CNT_W'(phase_limit));

    // Next blink state for the item in the input register
    always_comb
    begin
        mode_next      = mode_reg;
        cnt_next       = cnt_reg;
        blinks_next    = blinks_reg;
        lit_next       = lit_reg;
        led_next       = led_reg;
        on_ms_next     = on_ms_reg;
        off_ms_next    = off_ms_reg;
        burst_next     = burst_reg;
        flash_end_next = flash_end_reg;

        if (s1_type_reg == REQ_SET_MODE)
        begin
            case (s1_mode_reg)
                MODE_OFF:
                begin
                    mode_next   = MODE_OFF;
                    cnt_next    = '1;
                    blinks_next = '0;
                    lit_next    = 1'b0;
                    led_next    = 1'b0;
                end
                MODE_UNSUPPORTED:
                begin
                    mode_next   = MODE_UNSUPPORTED;
                    on_ms_next  = cfg_reg[CFG_UNSUPPORTED_BLINK];
                    off_ms_next = cfg_reg[CFG_UNSUPPORTED_BLINK];
                    burst_next  = BURST_SINGLE;
                end
                MODE_BOTDETECT:
                begin
                    mode_next   = MODE_BOTDETECT;
                    on_ms_next  = cfg_reg[CFG_BOTDETECT_ON];
                    off_ms_next = cfg_reg[CFG_BOTDETECT_OFF];
                    burst_next  = BURST_DOUBLE;
                end
                MODE_READWRITE:
                begin
                    // Flash only from off and only when enabled
                    if (rw_enabled && (mode_reg == MODE_OFF))
                    begin
                        mode_next      = MODE_READWRITE;
                        on_ms_next     = cfg_reg[CFG_READWRITE_ON];
                        off_ms_next    = cfg_reg[CFG_READWRITE_OFF];
                        burst_next     = BURST_SINGLE;
                        flash_end_next = s1_now_reg + TW'(cfg_reg[CFG_READWRITE_FLASH]);
                    end
                end
                default:
                begin
                    // Startup keeps its code; error and unknown codes become error
                    mode_next   = (s1_mode_reg == MODE_STARTUP) ? MODE_STARTUP : MODE_ERROR;
                    on_ms_next  = cfg_reg[CFG_ERROR_BLINK];
                    off_ms_next = cfg_reg[CFG_ERROR_BLINK];
                    burst_next  = BURST_SINGLE;
                end
            endcase
        end
        else if (mode_reg == MODE_OFF)
        begin
            // Hold: nothing moves while off
        end
        else if ((mode_reg == MODE_STARTUP && startup_done) || flash_expired)
        begin
            mode_next   = MODE_OFF;
            cnt_next    = '1;
            blinks_next = '0;
            lit_next    = 1'b0;
            led_next    = 1'b0;
        end
        else if (mode_reg == MODE_STARTUP)
        begin
            // Hold startup lighting until the delay passes
        end
        else if (!phase_hit)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (lit_reg)
        begin
            // End of an on phase
            blinks_next = blinks_reg + 1'b1;
            cnt_next    = '0;
            lit_next    = 1'b0;
            led_next    = 1'b0;
        end
        else
        begin
            // End of a gap or of the off time after a burst
            if (blinks_reg >= burst_reg)
            begin
                blinks_next = '0;
            end
            cnt_next = '0;
            lit_next = 1'b1;
            led_next = 1'b1;
        end
    end

    // Advance the blink state as the item moves to the output
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_STARTUP;
            cnt_reg       <= '0;
            blinks_reg    <= '0;
            lit_reg       <= 1'b0;
            led_reg       <= 1'b1;
            on_ms_reg     <= '0;
            off_ms_reg    <= '0;
            burst_reg     <= '0;
            flash_end_reg <= '0;
        end
        else if (advance && s1_valid_reg)
        begin
            mode_reg      <= mode_next;
            cnt_reg       <= cnt_next;
            blinks_reg    <= blinks_next;
            lit_reg       <= lit_next;
            led_reg       <= led_next;
            on_ms_reg     <= on_ms_next;
            off_ms_reg    <= off_ms_next;
            burst_reg     <= burst_next;
            flash_end_reg <= flash_end_next;
        end
    end

endmodule

// ----- hw/rtl/sled_chk.sv -----
module sled_chk (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        req_valid,
    input logic                        req_ready,
    input logic                        rsp_valid,
    input logic                        rsp_ready,
    input logic                        rsp_led_on,
    input logic [sled_pkg::MODE_W-1:0] rsp_mode
);
    import sled_pkg::*;

    // Off mode always shows a dark LED
    a_off_is_dark: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (rsp_mode == MODE_OFF)) |-> !rsp_led_on)
        else $error("LED lit in off mode");

    // A new response beat traces back to an accepted request beat through the input register
    a_rsp_from_req: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
        else $error("response beat without a matching request beat");

    // A stalled response beat holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_mode)
                                       && $stable(rsp_led_on)))
        else $error("stalled response beat changed");

endmodule

bind status_led_blink_pattern_top sled_chk u_sled_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (req.valid),
    .req_ready  (req.ready),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .rsp_led_on (rsp.led_on),
    .rsp_mode   (rsp.mode)
);
